// File: hw/rtl/vrc_pkg.sv
// vrc_pkg: shared types and constants of the viewport rectangle clipper.
// No dependencies; used by vrc_axis, viewport_rect_clipper and viewport_rect_clipper_tb.

package vrc_pkg;

   // world positions are fixed by the item format
   localparam int POS_W      = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   // register reset values
   localparam int CAM_WIDTH_RST  = 320;
   localparam int CAM_HEIGHT_RST = 240;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CAM_WORLD_X  = 3'd0,
      CSR_CAM_WORLD_Y  = 3'd1,
      CSR_CAM_WIDTH    = 3'd2,
      CSR_CAM_HEIGHT   = 3'd3,
      CSR_CAM_SCREEN_X = 3'd4,
      CSR_CAM_SCREEN_Y = 3'd5
   } csr_index_type;

   // per-stage load enables of the four-stage pipeline
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

endpackage

// File: hw/rtl/vrc_axis.sv
// vrc_axis: four-stage clip datapath for one axis (x or y).
// Depends on vrc_pkg; stage enables come from the top level.

module vrc_axis #(
   parameter int FRAC_BITS = 4,
   parameter int DIM_BITS  = 12
) (
   input  logic                            clock,
   input  vrc_pkg::stage_en_type           en,
   input  logic signed [vrc_pkg::POS_W-1:0] pos,
   input  logic signed [vrc_pkg::POS_W-1:0] cam,
   input  logic [DIM_BITS-1:0]             size,
   input  logic [DIM_BITS-1:0]             win,
   input  logic [DIM_BITS-1:0]             origin,
   output logic                            vis,
   output logic [DIM_BITS:0]               scr,
   output logic [DIM_BITS-1:0]             lo_cut,
   output logic [DIM_BITS-1:0]             len
);

   localparam int LO_W = vrc_pkg::POS_W + 1;
   localparam int HI_W = vrc_pkg::POS_W + 2;
   localparam int HALF = (2 ** FRAC_BITS) / 2;

   logic signed [HI_W-1:0] win_fx;
   assign win_fx = signed'(HI_W'(win) << FRAC_BITS);

   // stage 1: camera-relative near edge
   logic signed [LO_W-1:0] lo_s1_in, lo_s1_ff;
   logic [DIM_BITS-1:0]    size_s1_ff;

   assign lo_s1_in = LO_W'(pos) - LO_W'(cam);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         lo_s1_ff   <= lo_s1_in;
         size_s1_ff <= size;
      end
   end

   // stage 2: far edge, magnitude of near edge, off-window test on near edge
   logic signed [HI_W-1:0] lo_ext, size_fx;
   logic signed [HI_W-1:0] hi_s2_in, hi_s2_ff;
   logic [HI_W-1:0]        mag_s2_in, mag_s2_ff;
   logic                   neg_s2_ff, off_s2_in, off_s2_ff;
   logic [DIM_BITS-1:0]    size_s2_ff;

   assign lo_ext    = HI_W'(lo_s1_ff);
   assign size_fx   = signed'(HI_W'(size_s1_ff) << FRAC_BITS);
   assign hi_s2_in  = lo_ext + size_fx;
   assign mag_s2_in = lo_s1_ff[LO_W-1] ? unsigned'(-lo_ext) : unsigned'(lo_ext);
   assign off_s2_in = (lo_ext >= win_fx);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         hi_s2_ff   <= hi_s2_in;
         mag_s2_ff  <= mag_s2_in;
         neg_s2_ff  <= lo_s1_ff[LO_W-1];
         off_s2_ff  <= off_s2_in;
         size_s2_ff <= size_s1_ff;
      end
   end

   // stage 3: round both cuts to whole pixels (add half, truncate)
   logic [HI_W-1:0]        mag_sum;
   logic signed [HI_W-1:0] over;
   logic [DIM_BITS-1:0]    mag_rnd_s3_in, mag_rnd_s3_ff;
   logic [DIM_BITS-1:0]    cut_hi_s3_in, cut_hi_s3_ff;
   logic                   vis_s3_in, vis_s3_ff, neg_s3_ff;
   logic [DIM_BITS-1:0]    size_s3_ff;

   assign mag_sum       = mag_s2_ff + HI_W'(HALF);
   assign mag_rnd_s3_in = DIM_BITS'(mag_sum >> FRAC_BITS);
   assign over          = hi_s2_ff - win_fx + signed'(HI_W'(HALF));
   assign cut_hi_s3_in  = (hi_s2_ff >= win_fx) ? DIM_BITS'(unsigned'(over) >> FRAC_BITS)
                                               : '0;
   assign vis_s3_in     = !off_s2_ff && !hi_s2_ff[HI_W-1];

   always_ff @(posedge clock) begin
      if (en.s3) begin
         mag_rnd_s3_ff <= mag_rnd_s3_in;
         cut_hi_s3_ff  <= cut_hi_s3_in;
         vis_s3_ff     <= vis_s3_in;
         neg_s3_ff     <= neg_s2_ff;
         size_s3_ff    <= size_s2_ff;
      end
   end

   // stage 4: remaining length (saturates at zero) and screen start
   logic [DIM_BITS-1:0] cut_lo, start;
   logic [DIM_BITS+1:0] rem;
   logic                vis_s4_ff;
   logic [DIM_BITS:0]   scr_s4_in, scr_s4_ff;
   logic [DIM_BITS-1:0] lo_cut_s4_ff, len_s4_in, len_s4_ff;

   assign cut_lo    = neg_s3_ff ? mag_rnd_s3_ff : '0;
   assign start     = neg_s3_ff ? '0 : mag_rnd_s3_ff;
   assign rem       = (DIM_BITS+2)'(size_s3_ff) - (DIM_BITS+2)'(cut_lo)
                    - (DIM_BITS+2)'(cut_hi_s3_ff);
   assign len_s4_in = rem[DIM_BITS+1] ? '0 : rem[DIM_BITS-1:0];
   assign scr_s4_in = (DIM_BITS+1)'(origin) + (DIM_BITS+1)'(start);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         vis_s4_ff    <= vis_s3_ff;
         scr_s4_ff    <= scr_s4_in;
         lo_cut_s4_ff <= cut_lo;
         len_s4_ff    <= len_s4_in;
      end
   end

   assign vis    = vis_s4_ff;
   assign scr    = scr_s4_ff;
   assign lo_cut = lo_cut_s4_ff;
   assign len    = len_s4_ff;

endmodule

// File: hw/rtl/viewport_rect_clipper.sv
// viewport_rect_clipper: top level, camera registers, pipeline flow control.
// Depends on vrc_pkg and vrc_axis.

// Clips one rectangle per item against the camera window. Items move through a
// four-stage pipeline (relative position, far edge and magnitude, rounding,
// draw size and screen start); a new item is taken every cycle while the result
// side is ready. Each stage holds its item while the stage after it is full and
// stalled, so empty stages keep filling while a finished result waits. Camera
// registers are read live by every stage; the user must write them only while
// no item is in flight, which the block itself does not enforce. When the
// rectangle is not visible, rsp_tuser is low and all of rsp_tdata is zero.

module viewport_rect_clipper #(
   parameter int FRAC_BITS = 4,
   parameter int DIM_BITS  = 12
) (
   input  logic clock,
   input  logic reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pos_x, pos_y, rect_width, rect_height, padded to a whole number of bytes
   input  logic [((2*vrc_pkg::POS_W+2*DIM_BITS+7)/8)*8-1:0] req_tdata,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // screen_x, screen_y, clip_left, clip_top, draw_width, draw_height, zero fill
   output logic [((6*DIM_BITS+2+7)/8)*8-1:0]     rsp_tdata,
   // visible
   output logic                                  rsp_tuser,

   input  logic                                  csr_we,
   input  logic [vrc_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [vrc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int PW         = vrc_pkg::POS_W;
   localparam int RSP_W      = 6*DIM_BITS + 2;
   localparam int RSP_DATA_W = ((RSP_W + 7) / 8) * 8;

   // camera registers
   logic signed [PW-1:0] cam_world_x_ff, cam_world_y_ff;
   logic [DIM_BITS-1:0]  cam_width_ff, cam_height_ff, cam_screen_x_ff, cam_screen_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_world_x_ff  <= '0;
         cam_world_y_ff  <= '0;
         cam_width_ff    <= DIM_BITS'(vrc_pkg::CAM_WIDTH_RST);
         cam_height_ff   <= DIM_BITS'(vrc_pkg::CAM_HEIGHT_RST);
         cam_screen_x_ff <= '0;
         cam_screen_y_ff <= '0;
      end else if (csr_we) begin
         case (vrc_pkg::csr_index_type'(csr_addr))
            vrc_pkg::CSR_CAM_WORLD_X:  cam_world_x_ff  <= csr_wdata[PW-1:0];
            vrc_pkg::CSR_CAM_WORLD_Y:  cam_world_y_ff  <= csr_wdata[PW-1:0];
            vrc_pkg::CSR_CAM_WIDTH:    cam_width_ff    <= csr_wdata[DIM_BITS-1:0];
            vrc_pkg::CSR_CAM_HEIGHT:   cam_height_ff   <= csr_wdata[DIM_BITS-1:0];
            vrc_pkg::CSR_CAM_SCREEN_X: cam_screen_x_ff <= csr_wdata[DIM_BITS-1:0];
            vrc_pkg::CSR_CAM_SCREEN_Y: cam_screen_y_ff <= csr_wdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   // input item fields
   logic signed [PW-1:0] pos_x, pos_y;
   logic [DIM_BITS-1:0]  rect_width, rect_height;

   assign pos_x       = req_tdata[PW-1:0];
   assign pos_y       = req_tdata[2*PW-1:PW];
   assign rect_width  = req_tdata[2*PW+DIM_BITS-1:2*PW];
   assign rect_height = req_tdata[2*PW+2*DIM_BITS-1:2*PW+DIM_BITS];

   // flow control: a stage loads when it is empty or its item moves on
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   vrc_pkg::stage_en_type en;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign en.s1 = rdy1;
   assign en.s2 = rdy2;
   assign en.s3 = rdy3;
   assign en.s4 = rdy4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

   // per-axis datapaths
   logic                vis_x, vis_y;
   logic [DIM_BITS:0]   scr_x, scr_y;
   logic [DIM_BITS-1:0] cut_x, cut_y, len_x, len_y;

   vrc_axis #(.FRAC_BITS(FRAC_BITS), .DIM_BITS(DIM_BITS)) u_axis_x (
      .clock  (clock),
      .en     (en),
      .pos    (pos_x),
      .cam    (cam_world_x_ff),
      .size   (rect_width),
      .win    (cam_width_ff),
      .origin (cam_screen_x_ff),
      .vis    (vis_x),
      .scr    (scr_x),
      .lo_cut (cut_x),
      .len    (len_x)
   );

   vrc_axis #(.FRAC_BITS(FRAC_BITS), .DIM_BITS(DIM_BITS)) u_axis_y (
      .clock  (clock),
      .en     (en),
      .pos    (pos_y),
      .cam    (cam_world_y_ff),
      .size   (rect_height),
      .win    (cam_height_ff),
      .origin (cam_screen_y_ff),
      .vis    (vis_y),
      .scr    (scr_y),
      .lo_cut (cut_y),
      .len    (len_y)
   );

   // a rectangle off either axis reports all-zero fields
   logic              visible;
   logic [RSP_W-1:0]  rsp_fields;

   assign visible    = vis_x && vis_y;
   assign rsp_fields = {len_y, len_x, cut_y, cut_x, scr_y, scr_x} & {RSP_W{visible}};
   assign rsp_tdata  = RSP_DATA_W'(rsp_fields);
   assign rsp_tuser  = visible;

endmodule

// File: hw/rtl/vrc_checker.sv
// vrc_checker: port-level assertions for viewport_rect_clipper, with its bind.
// Depends on the top level's port list only.

module vrc_checker #(
   parameter int DIM_BITS = 12
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [((6*DIM_BITS+2+7)/8)*8-1:0]  rsp_tdata,
   input logic                               rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("result item changed while stalled");

   // not visible means every other field is zero
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("hidden rectangle with nonzero fields");

   // the pipeline only refuses items when it is full and the result side stalls
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without a blocked result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind viewport_rect_clipper vrc_checker #(.DIM_BITS(DIM_BITS)) u_vrc_checker (.*);

// File: verif/viewport_rect_clipper_tb.sv
// viewport_rect_clipper_tb: self-checking testbench for the viewport rectangle clipper.
// Streams rectangles through the clipper under several camera settings and checks every
// result against an in-bench clip computation. Depends on vrc_pkg and viewport_rect_clipper.

module viewport_rect_clipper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 4;
   localparam int DIM         = 12;
   localparam int HALF        = (1 << FRAC) >> 1;
   localparam int LATENCY     = 4;
   localparam int STALL_LIMIT = 5000;
   localparam int SEGMENTS    = 9;
   localparam int SEG_ITEMS   = 100;

   // request item, pos_x in the lowest bits
   typedef struct packed {
      logic [DIM-1:0]                   h;
      logic [DIM-1:0]                   w;
      logic signed [vrc_pkg::POS_W-1:0] y;
      logic signed [vrc_pkg::POS_W-1:0] x;
   } rect_type;

   // response tdata, screen_x in the lowest bits
   typedef struct packed {
      logic [5:0]     fill;
      logic [DIM-1:0] draw_h;
      logic [DIM-1:0] draw_w;
      logic [DIM-1:0] clip_top;
      logic [DIM-1:0] clip_left;
      logic [DIM:0]   scr_y;
      logic [DIM:0]   scr_x;
   } clip_res_type;

   typedef struct packed {
      logic         visible;
      clip_res_type res;
   } clip_type;

   typedef struct packed {
      logic signed [vrc_pkg::POS_W-1:0] wx;
      logic signed [vrc_pkg::POS_W-1:0] wy;
      logic [DIM-1:0]                   width;
      logic [DIM-1:0]                   height;
      logic [DIM-1:0]                   sx;
      logic [DIM-1:0]                   sy;
   } cam_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   rect_type                       req_item = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   clip_res_type                   rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we = 1'b0;
   vrc_pkg::csr_index_type         csr_addr = vrc_pkg::CSR_CAM_WORLD_X;
   logic [vrc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   cam_type  camera = '{wx: '0, wy: '0, width: DIM'(vrc_pkg::CAM_WIDTH_RST),
                        height: DIM'(vrc_pkg::CAM_HEIGHT_RST), sx: '0, sy: '0};
   rect_type pending_rects[$];
   clip_type expected_clips[$];
   clip_type want_clip;
   int       send_idle_pct = 6;
   int       recv_idle_pct = 61;
   int       mismatch_count = 0;
   int       stall_cycles = 0;

   viewport_rect_clipper #(
      .FRAC_BITS(FRAC),
      .DIM_BITS (DIM)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_item),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one axis of the clip; cut amounts round half away from zero
   function automatic void clip_axis(input longint pos, input longint cam, input longint size,
                                     input longint win, input longint origin,
                                     output bit vis, output logic [DIM:0] scr,
                                     output logic [DIM-1:0] cut, output logic [DIM-1:0] len);
      longint lo, hi, w, cut_lo, cut_hi, start, rem;
      lo     = pos - cam;
      hi     = lo + (size <<< FRAC);
      w      = win <<< FRAC;
      vis    = !(lo >= w || hi < 0);
      cut_lo = 0;
      cut_hi = 0;
      start  = 0;
      if (lo < 0) begin
         cut_lo = (-lo + HALF) >>> FRAC;
      end else begin
         start = (lo + HALF) >>> FRAC;
      end
      if (hi >= w) begin
         cut_hi = (hi - w + HALF) >>> FRAC;
      end
      rem = size - cut_lo - cut_hi;
      if (rem < 0) begin
         rem = 0;
      end
      scr = (DIM+1)'(origin + start);
      cut = DIM'(cut_lo);
      len = DIM'(rem);
   endfunction

   function automatic clip_type clip_rect(input rect_type r, input cam_type c);
      clip_type       e;
      bit             vis_x, vis_y;
      logic [DIM:0]   sx, sy;
      logic [DIM-1:0] cl, ct, dw, dh;
      e = '0;
      clip_axis($signed(r.x), $signed(c.wx), r.w, c.width, c.sx, vis_x, sx, cl, dw);
      clip_axis($signed(r.y), $signed(c.wy), r.h, c.height, c.sy, vis_y, sy, ct, dh);
      if (vis_x && vis_y) begin
         e.visible       = 1'b1;
         e.res.scr_x     = sx;
         e.res.scr_y     = sy;
         e.res.clip_left = cl;
         e.res.clip_top  = ct;
         e.res.draw_w    = dw;
         e.res.draw_h    = dh;
      end
      return e;
   endfunction

   task automatic add_rect(input longint px, input longint py, input int w, input int h);
      rect_type r;
      r.x = px[vrc_pkg::POS_W-1:0];
      r.y = py[vrc_pkg::POS_W-1:0];
      r.w = DIM'(w);
      r.h = DIM'(h);
      pending_rects.push_back(r);
   endtask

   // position around the window so that all visibility cases are likely
   function automatic logic [vrc_pkg::POS_W-1:0] near_pos(input longint cam, input int size,
                                                          input int win);
      longint span_lo, span_hi, v;
      span_lo = -longint'(size + 4) * 16;
      span_hi = longint'(win + 4) * 16;
      v = cam + span_lo + longint'($urandom_range(int'(span_hi - span_lo)));
      if ($urandom_range(3) == 0) begin
         v = (v & ~longint'(15)) | HALF;
      end
      if (v > 8388607) begin
         v = 8388607;
      end else if (v < -8388608) begin
         v = -8388608;
      end
      return v[vrc_pkg::POS_W-1:0];
   endfunction

   task automatic add_random_rect();
      rect_type r;
      if ($urandom_range(99) < 15) begin
         r = rect_type'({$urandom(), $urandom(), $urandom()});
      end else begin
         r.w = ($urandom_range(3) == 0) ? DIM'($urandom_range(4095)) : DIM'($urandom_range(80));
         r.h = ($urandom_range(3) == 0) ? DIM'($urandom_range(4095)) : DIM'($urandom_range(80));
         r.x = near_pos($signed(camera.wx), r.w, camera.width);
         r.y = near_pos($signed(camera.wy), r.h, camera.height);
      end
      pending_rects.push_back(r);
   endtask

   // block is idle once nothing is queued, driven or outstanding
   task automatic drain();
      while (pending_rects.size() != 0 || req_tvalid || expected_clips.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_camera(input cam_type c);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= vrc_pkg::CSR_CAM_WORLD_X;
      csr_wdata <= c.wx;
      @(posedge clock);
      csr_addr  <= vrc_pkg::CSR_CAM_WORLD_Y;
      csr_wdata <= c.wy;
      @(posedge clock);
      csr_addr  <= vrc_pkg::CSR_CAM_WIDTH;
      csr_wdata <= vrc_pkg::CSR_DATA_W'(c.width);
      @(posedge clock);
      csr_addr  <= vrc_pkg::CSR_CAM_HEIGHT;
      csr_wdata <= vrc_pkg::CSR_DATA_W'(c.height);
      @(posedge clock);
      csr_addr  <= vrc_pkg::CSR_CAM_SCREEN_X;
      csr_wdata <= vrc_pkg::CSR_DATA_W'(c.sx);
      @(posedge clock);
      csr_addr  <= vrc_pkg::CSR_CAM_SCREEN_Y;
      csr_wdata <= vrc_pkg::CSR_DATA_W'(c.sy);
      @(posedge clock);
      csr_we    <= 1'b0;
      camera = c;
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
         end
      end
   endtask

   // driver: expectation is computed with the camera in force when the item is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_clips.push_back(clip_rect(req_item, camera));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_rects.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_item   <= pending_rects.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_clips.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: unexpected item, visible %0b", $realtime, rsp_tuser);
            end
         end else begin
            want_clip = expected_clips.pop_front();
            check_field("visible", want_clip.visible, rsp_tuser);
            check_field("screen_x", want_clip.res.scr_x, rsp_tdata.scr_x);
            check_field("screen_y", want_clip.res.scr_y, rsp_tdata.scr_y);
            check_field("clip_left", want_clip.res.clip_left, rsp_tdata.clip_left);
            check_field("clip_top", want_clip.res.clip_top, rsp_tdata.clip_top);
            check_field("draw_width", want_clip.res.draw_w, rsp_tdata.draw_w);
            check_field("draw_height", want_clip.res.draw_h, rsp_tdata.draw_h);
         end
      end
   end

   // watchdog: only counts while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_rects.size() == 0 && !req_tvalid && expected_clips.size() == 0)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      cam_type corner_cam, zero_cam, seg_cam;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset camera: 320x240 window at world origin
      add_rect(0, 0, 0, 0);
      add_rect(160, 320, 50, 30);
      add_rect(-88, 100, 20, 10);          // left cut lands on a half pixel
      add_rect(-87, 100, 20, 10);
      add_rect(4816, 50, 40, 10);          // right cut
      add_rect(100, -40, 10, 20);          // top cut
      add_rect(100, 3800, 10, 30);         // bottom cut
      add_rect(5120, 0, 10, 10);           // starts on the right edge: hidden
      add_rect(5119, 0, 1, 1);
      add_rect(-160, 0, 10, 10);           // far edge touches left border
      add_rect(-161, 0, 10, 10);
      add_rect(0, 3840, 10, 10);
      add_rect(0, -161, 10, 10);
      add_rect(-1600, -1600, 4095, 4095);  // covers the whole window
      add_rect(-8388608, 8388607, 4095, 4095);
      add_rect(8388607, -8388608, 4095, 0);
      drain();

      corner_cam = '{wx: 24'h800000, wy: 24'h7fffff, width: 12'd4095, height: 12'd1,
                     sx: 12'd4095, sy: 12'd0};
      write_camera(corner_cam);
      add_rect(-8388608, 8388607, 1, 1);
      add_rect(-8388608 + 65519, 8388607, 4095, 0);  // largest screen x
      add_rect(8388607, 8388607, 0, 0);
      add_rect(-8388608, -8388608, 4095, 4095);
      drain();

      // zero-size window: cuts overrun the size, draw size saturates
      zero_cam = '{wx: '0, wy: '0, width: '0, height: '0, sx: 12'd100, sy: 12'd200};
      write_camera(zero_cam);
      add_rect(-8, -8, 1, 1);
      add_rect(0, 0, 5, 5);
      add_rect(-40, -24, 3, 2);
      drain();

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 3) begin
            send_idle_pct = 6;
            recv_idle_pct = 61;
         end else if (seg < 6) begin
            send_idle_pct = 61;
            recv_idle_pct = 6;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (seg == 0) begin
            seg_cam = '{wx: 24'h7fffff, wy: 24'h800000, width: 12'd4095, height: 12'd4095,
                        sx: 12'd4095, sy: 12'd4095};
         end else if (seg == 1) begin
            seg_cam = '{wx: 24'h800000, wy: 24'h7fffff, width: 12'd1, height: 12'd1,
                        sx: 12'd0, sy: 12'd0};
         end else begin
            seg_cam.wx     = $urandom_range(1) ? 24'($urandom())
                                               : 24'(int'($urandom_range(4000)) - 2000);
            seg_cam.wy     = $urandom_range(1) ? 24'($urandom())
                                               : 24'(int'($urandom_range(4000)) - 2000);
            seg_cam.width  = $urandom_range(1) ? DIM'($urandom_range(4095, 1))
                                               : DIM'($urandom_range(400, 1));
            seg_cam.height = $urandom_range(1) ? DIM'($urandom_range(4095, 1))
                                               : DIM'($urandom_range(400, 1));
            seg_cam.sx     = DIM'($urandom_range(4095));
            seg_cam.sy     = DIM'($urandom_range(4095));
         end
         write_camera(seg_cam);
         repeat (SEG_ITEMS) add_random_rect();
         drain();
      end

      if (mismatch_count == 0 && expected_clips.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/vrc_pkg.sv
hw/rtl/vrc_axis.sv
hw/rtl/viewport_rect_clipper.sv
hw/rtl/vrc_checker.sv
verif/viewport_rect_clipper_tb.sv
